>>> hw/rtl/fdmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmd_pkg
// Shared widths, register indexes and reset values of the frame-difference
// motion detector.
// ----------------------------------------------------------------------------
package fdmd_pkg;

  localparam int PIX_W = 8;
  localparam int CNT_W = 17;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 17;

  localparam int S_TDATA_W = 8;
  // motion_detected + changed_count, rounded up to whole bytes
  localparam int M_TDATA_W = 24;
  localparam int M_TDATA_PAD = M_TDATA_W - 1 - CNT_W;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [CNT_W-1:0] count_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam count_t COUNT_MAX = '1;

  localparam cfg_addr_t REG_DIFF_THRESHOLD = 2'd0;
  localparam cfg_addr_t REG_MIN_CHANGED = 2'd1;
  localparam cfg_addr_t REG_FRAME_LENGTH = 2'd2;

  localparam pixel_t RST_DIFF_THRESHOLD = 8'd30;
  localparam count_t RST_MIN_CHANGED = 17'd500;
  localparam count_t RST_FRAME_LENGTH = 17'd65536;

endpackage

>>> hw/rtl/fdmd_frame_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmd_frame_store
// Single-port reference frame memory, read-first: one access returns the
// stored pixel and replaces it with the new one in the same cycle.
// ----------------------------------------------------------------------------
module fdmd_frame_store #(
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  fdmd_pkg::pixel_t         wr_data,
  output fdmd_pkg::pixel_t         rd_data
);
  import fdmd_pkg::*;

  pixel_t mem [DEPTH];

  // old contents come out, new pixel goes in
  always_ff @(posedge clk) begin
    if (en) begin
      rd_data <= mem[addr];
      mem[addr] <= wr_data;
    end
  end

endmodule

>>> hw/rtl/frame_difference_motion_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_difference_motion_detector_core
// Counts pixels that changed against the previous frame and reports one
// result per frame.
//
//   channel  direction  handshake            payload
//   s_*      in         s_tvalid / s_tready  tdata[7:0] pixel
//   m_*      out        m_tvalid / m_tready  tdata[0] motion, [17:1] count;
//                                            tuser first_frame
//   cfg_*    in         cfg_valid/cfg_ready  cfg_addr register, cfg_data value
//
// one pixel per cycle unless a held result stalls input; a pixel passes the store
// read/write, then compare and count into the result register.
// the single read-first store port sets the rate: one access per pixel.
// reset clears position, counters and the reference flag; store is not cleared.
// a held result stalls input only when the pixel behind it ends another frame.
// ----------------------------------------------------------------------------
module frame_difference_motion_detector_core #(
  parameter int MAX_FRAME_PIXELS = 65536
) (
  input  logic                        clk,
  input  logic                        rst,
  // pixel input
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [fdmd_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] pixel
  // frame result
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [fdmd_pkg::M_TDATA_W-1:0] m_tdata,  // [0] motion_detected,
                                                    // [17:1] changed_count
  output logic                        m_tuser,      // [0] first_frame
  // register writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  fdmd_pkg::cfg_addr_t         cfg_addr,
  input  fdmd_pkg::cfg_data_t         cfg_data
);
  import fdmd_pkg::*;

  localparam int PW = $clog2(MAX_FRAME_PIXELS);
  localparam int LW = (PW + 1 > CNT_W) ? PW + 1 : CNT_W;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_FRAME_PIXELS);

  // configuration
  pixel_t diff_threshold;
  count_t min_changed;
  count_t frame_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_threshold <= RST_DIFF_THRESHOLD;
      min_changed <= RST_MIN_CHANGED;
      frame_length <= RST_FRAME_LENGTH;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_DIFF_THRESHOLD: diff_threshold <= cfg_data[PIX_W-1:0];
        REG_MIN_CHANGED: min_changed <= cfg_data;
        REG_FRAME_LENGTH: frame_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: position, store access
  logic [PW-1:0] position;
  logic          ref_valid;
  logic [LW-1:0] len_eff;
  logic [LW-1:0] pos_inc;
  logic          in_last;
  logic          s_accept;

  always_comb begin
    len_eff = LW'(frame_length);
    if (frame_length == '0) begin
      len_eff = LW'(1);
    end else if (len_eff > MAX_LEN) begin
      len_eff = MAX_LEN;
    end
    pos_inc = LW'(position) + LW'(1);
    in_last = (pos_inc >= len_eff);
  end

  // stage 1 registers
  logic   s1_valid;
  logic   s1_last;
  logic   s1_cmp;
  pixel_t s1_pixel;
  pixel_t s1_old;
  logic   s1_go;

  assign s1_go = s1_valid && (!s1_last || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_go;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      ref_valid <= 1'b0;
    end else if (s_accept) begin
      if (in_last) begin
        position <= '0;
        ref_valid <= 1'b1;
      end else begin
        position <= pos_inc[PW-1:0];
      end
    end
  end

  fdmd_frame_store #(
    .DEPTH(MAX_FRAME_PIXELS)
  ) u_store (
    .clk(clk),
    .en(s_accept),
    .addr(position),
    .wr_data(s_tdata[PIX_W-1:0]),
    .rd_data(s1_old)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_pixel <= s_tdata[PIX_W-1:0];
      s1_last <= in_last;
      s1_cmp <= ref_valid;
    end
  end

  // stage 1: compare and count
  pixel_t diff;
  logic   changed;
  count_t change_count;
  count_t count_sum;

  always_comb begin
    diff = (s1_pixel > s1_old) ? s1_pixel - s1_old : s1_old - s1_pixel;
    changed = s1_cmp && (diff > diff_threshold);
    count_sum = (changed && change_count != COUNT_MAX) ? change_count + count_t'(1)
                                                       : change_count;
  end

  logic   res_motion;
  count_t res_count;
  logic   res_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      change_count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_go) begin
        change_count <= s1_last ? '0 : count_sum;
      end
      if (s1_go && s1_last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      res_motion <= s1_cmp && (count_sum > min_changed);
      res_count <= s1_cmp ? count_sum : '0;
      res_first <= !s1_cmp;
    end
  end

  assign m_tdata = {{M_TDATA_PAD{1'b0}}, res_count, res_motion};
  assign m_tuser = res_first;

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    LW'(position) < MAX_LEN)
    else $error("position beyond frame store");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_pixel) && $stable(s1_old))
    else $error("stalled stage 1 item changed");

  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_last |=> change_count == '0)
    else $error("count not cleared at frame end");

  a_first_no_motion: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_first |-> !res_motion && res_count == '0)
    else $error("fill frame reported changes");

  a_ref_sticky: assert property (@(posedge clk) disable iff (rst)
    ref_valid |=> ref_valid)
    else $error("reference flag dropped");

  a_no_result_before_ref: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_cmp |-> change_count == '0)
    else $error("count moved during fill frame");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the frame-difference motion detector core. Pixels
// stream in under random backpressure; a frame-change tracker keeps its own
// copy of the previous frame and predicts every per-frame result, which is
// compared field by field as the results leave the core.
// ----------------------------------------------------------------------------
module testbench;

  import fdmd_pkg::*;

  localparam int          MAX_PIX      = 65536;
  localparam int          FILL_LEN     = 48;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          SETTLE       = 8;
  localparam int          RANDOM_ITEMS = 250;
  localparam int unsigned LIMIT        = 200000;

  localparam cfg_addr_t REG_UNUSED = 2'd3;

  typedef enum {GAPS_NONE, GAPS_RANDOM, GAPS_RARE} gap_mode_t;
  typedef enum {PIX_RANDOM, PIX_SAME, PIX_NEAR, PIX_FLIP, PIX_EDGE, PIX_MIX} pix_kind_t;

  typedef struct packed {
    logic   motion;
    count_t count;
    logic   first;
  } frame_result_t;

  // --------------------------------------------------------------------------
  class frame_change_tracker;
    pixel_t        frame_mem [MAX_PIX];
    bit            have_ref;
    int unsigned   pos;
    count_t        changed;
    pixel_t        thresh;
    count_t        min_chg;
    count_t        frame_len;
    frame_result_t expected_frames [$];
    int            errors;

    function new();
      have_ref  = 1'b0;
      pos       = 0;
      changed   = '0;
      thresh    = RST_DIFF_THRESHOLD;
      min_chg   = RST_MIN_CHANGED;
      frame_len = RST_FRAME_LENGTH;
      errors    = 0;
    endfunction

    function void set_register(cfg_addr_t addr, cfg_data_t data);
      case (addr)
        REG_DIFF_THRESHOLD: thresh = data[PIX_W-1:0];
        REG_MIN_CHANGED:    min_chg = data[CNT_W-1:0];
        REG_FRAME_LENGTH:   frame_len = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned frame_span();
      if (frame_len == '0) return 1;
      if (32'(frame_len) > MAX_PIX) return MAX_PIX;
      return 32'(frame_len);
    endfunction

    function int unsigned pixels_to_end();
      int unsigned span;
      span = frame_span();
      return (pos + 1 >= span) ? 1 : span - pos;
    endfunction

    function void note_pixel(pixel_t px);
      int unsigned   span;
      int unsigned   diff;
      frame_result_t r;
      span = frame_span();
      if (pos < MAX_PIX) begin
        if (have_ref) begin
          if (px > frame_mem[pos]) diff = 32'(px - frame_mem[pos]);
          else diff = 32'(frame_mem[pos] - px);
          if (diff > 32'(thresh) && changed != COUNT_MAX) changed++;
        end
        frame_mem[pos] = px;
      end
      if (pos + 1 >= span) begin
        r.first  = !have_ref;
        r.count  = have_ref ? changed : '0;
        r.motion = have_ref && (changed > min_chg);
        expected_frames.push_back(r);
        have_ref = 1'b1;
        pos      = 0;
        changed  = '0;
      end else begin
        pos++;
      end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] tdata, logic tuser);
      frame_result_t r;
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tuser=%b", $time, tdata, tuser);
        errors++;
        return;
      end
      r = expected_frames.pop_front();
      if (tdata[0] !== r.motion) begin
        $display("%0t: motion_detected expected %0d actual %0d", $time, r.motion, tdata[0]);
        errors++;
      end
      if (tdata[CNT_W:1] !== r.count) begin
        $display("%0t: changed_count expected %0d actual %0d", $time, r.count,
                 tdata[CNT_W:1]);
        errors++;
      end
      if (tuser !== r.first) begin
        $display("%0t: first_frame expected %0d actual %0d", $time, r.first, tuser);
        errors++;
      end
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction
  endclass
  // --------------------------------------------------------------------------

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // [7:0] pixel
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // [0] motion_detected, [17:1] changed_count
  logic                 m_tuser;   // [0] first_frame
  logic                 cfg_valid;
  logic                 cfg_ready;
  cfg_addr_t            cfg_addr;
  cfg_data_t            cfg_data;

  frame_change_tracker tracker = new();
  gap_mode_t           gap_mode = GAPS_RANDOM;
  bit                  hold_req = 1'b0;
  int unsigned         cycle_count = 0;

  frame_difference_motion_detector_core #(
    .MAX_FRAME_PIXELS(MAX_PIX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("** frame_difference_motion_detector_core: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
  end

  function automatic int draw_gap();
    case (gap_mode)
      GAPS_NONE: return 0;
      GAPS_RARE: return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 6) : 0;
      default:   return $urandom_range(0, 6);
    endcase
  endfunction

  // exact difference where it fits, otherwise the far end of the range
  function automatic pixel_t offset_pixel(pixel_t old, int d);
    if (old + d <= 255) return pixel_t'(old + d);
    if (old >= d) return pixel_t'(old - d);
    return (old < 128) ? 8'd255 : 8'd0;
  endfunction

  function automatic pixel_t choose_pixel(pix_kind_t kind);
    pixel_t    old;
    pix_kind_t k;
    int        d;
    old = tracker.frame_mem[tracker.pos];
    k = kind;
    if (k == PIX_MIX) begin
      case ($urandom_range(0, 4))
        0:       k = PIX_RANDOM;
        1:       k = PIX_SAME;
        2:       k = PIX_NEAR;
        3:       k = PIX_FLIP;
        default: k = PIX_EDGE;
      endcase
    end
    case (k)
      PIX_SAME: return old;
      PIX_NEAR: return offset_pixel(old, $urandom_range(0, 8));
      PIX_FLIP: return (old < 128) ? 8'd255 : 8'd0;
      PIX_EDGE: begin
        // right at the threshold or one above it
        d = tracker.thresh + $urandom_range(0, 1);
        if (d > 255) d = 255;
        return offset_pixel(old, d);
      end
      default:  return pixel_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic put_pixel(pix_kind_t kind);
    int     gap;
    pixel_t px;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    px = choose_pixel(kind);
    s_tdata  <= px;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    tracker.note_pixel(px);
  endtask

  task automatic send_pixels(int n, pix_kind_t kind);
    repeat (n) put_pixel(kind);
  endtask

  task automatic write_reg(cfg_addr_t addr, cfg_data_t data);
    cfg_addr  <= addr;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(addr, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending, let every expected result out, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic shuffle_registers();
    int pick;
    if ($urandom_range(0, 1)) begin
      pick = $urandom_range(0, 3);
      write_reg(REG_DIFF_THRESHOLD, cfg_data_t'((pick == 0) ? 0 : (pick == 1) ? 255 :
                $urandom_range(0, 64)));
    end
    if ($urandom_range(0, 1)) begin
      pick = $urandom_range(0, 7);
      write_reg(REG_MIN_CHANGED, cfg_data_t'((pick == 6) ? 65536 :
                (pick == 7) ? $urandom_range(0, 131071) : $urandom_range(0, 12)));
    end
    if ($urandom_range(0, 1)) begin
      pick = $urandom_range(0, 7);
      write_reg(REG_FRAME_LENGTH, cfg_data_t'((pick == 6) ? 0 :
                (pick == 7) ? $urandom_range(17, 40) : $urandom_range(1, 16)));
    end
    if ($urandom_range(0, 7) == 0) begin
      write_reg(REG_UNUSED, cfg_data_t'($urandom_range(0, 131071)));
    end
  endtask

  // result sink: random gaps per transfer, one long hold on request
  initial begin : result_sink
    int gap;
    m_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = draw_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  initial begin : stimulus
    int random_items;
    int frames;
    int n;
    int cut;
    random_items = 0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_addr  <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_UNUSED, cfg_data_t'($urandom_range(0, 131071)));

    // first frame fills every store entry that later frames compare against
    write_reg(REG_FRAME_LENGTH, FILL_LEN);
    send_pixels(tracker.pixels_to_end(), PIX_RANDOM);
    drain();

    // reset threshold and minimum, differences at and just above the threshold
    write_reg(REG_FRAME_LENGTH, 6);
    send_pixels(6, PIX_EDGE);
    drain();

    // top threshold: nothing can count
    write_reg(REG_DIFF_THRESHOLD, 255);
    write_reg(REG_FRAME_LENGTH, 3);
    send_pixels(3, PIX_FLIP);
    drain();

    // zero threshold and zero minimum
    write_reg(REG_DIFF_THRESHOLD, 0);
    write_reg(REG_MIN_CHANGED, 0);
    write_reg(REG_FRAME_LENGTH, 4);
    send_pixels(4, PIX_EDGE);
    drain();

    // zero length behaves as one pixel per frame
    write_reg(REG_FRAME_LENGTH, 0);
    send_pixels(2, PIX_FLIP);
    drain();
    write_reg(REG_FRAME_LENGTH, 1);
    send_pixels(1, PIX_SAME);
    drain();

    // top minimum never reached
    write_reg(REG_MIN_CHANGED, 65536);
    write_reg(REG_FRAME_LENGTH, 3);
    send_pixels(3, PIX_FLIP);
    drain();

    // length shrinks below the current position mid-frame
    write_reg(REG_MIN_CHANGED, 1);
    write_reg(REG_FRAME_LENGTH, 10);
    send_pixels(4, PIX_FLIP);
    drain();
    write_reg(REG_FRAME_LENGTH, 3);
    send_pixels(1, PIX_FLIP);
    drain();

    // length grows mid-frame
    write_reg(REG_FRAME_LENGTH, 3);
    send_pixels(2, PIX_NEAR);
    drain();
    write_reg(REG_FRAME_LENGTH, 5);
    send_pixels(tracker.pixels_to_end(), PIX_NEAR);
    drain();

    // oversized length acts as the full store, so no frame end until cut short
    write_reg(REG_MIN_CHANGED, 3);
    write_reg(REG_FRAME_LENGTH, 131071);
    send_pixels(20, PIX_FLIP);
    drain();
    write_reg(REG_FRAME_LENGTH, 2);
    send_pixels(tracker.pixels_to_end(), PIX_FLIP);
    drain();

    // one result per pixel against a long receiver hold, so the input stalls
    gap_mode = GAPS_NONE;
    write_reg(REG_FRAME_LENGTH, 1);
    hold_req = 1'b1;
    send_pixels(48, PIX_MIX);
    drain();

    while (random_items < RANDOM_ITEMS) begin
      drain();
      gap_mode = ($urandom_range(0, 4) == 0) ? GAPS_NONE : GAPS_RANDOM;
      shuffle_registers();
      frames = $urandom_range(1, 4);
      repeat (frames) begin
        n = tracker.pixels_to_end();
        if (n > 1 && $urandom_range(0, 5) == 0) begin
          cut = $urandom_range(1, n - 1);
          send_pixels(cut, PIX_MIX);
          random_items += cut;
          drain();
          write_reg(REG_FRAME_LENGTH, cfg_data_t'($urandom_range(0, 16)));
          n = tracker.pixels_to_end();
        end
        send_pixels(n, PIX_MIX);
        random_items += n;
      end
    end
    drain();

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("** frame_difference_motion_detector_core: PASSED **");
    end else begin
      $display("** frame_difference_motion_detector_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> frame_difference_motion_detector_core.f
hw/rtl/fdmd_pkg.sv
hw/rtl/fdmd_frame_store.sv
hw/rtl/frame_difference_motion_detector_core.sv
bench/testbench.sv
